[rtl/mrf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrf_pkg: shared types and constants of the modem reply framer
// Frame size, protocol bytes, id length lookup, phase and register codes.
// ---------------------------------------------------------------------------
package mrf_pkg;

  // Largest frame the cell row holds
  localparam int MAX_FRAME = 25;
  // Width of a byte count that can hold MAX_FRAME itself
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  // Width of an index into the cell row
  localparam int IDX_W     = $clog2(MAX_FRAME);

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] ACK_BYTE   = 8'h06;
  localparam logic [7:0] FIRST_ID   = 8'h50;
  localparam logic [7:0] LAST_ID    = 8'h58;

  // Input item kinds carried in tuser
  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CMD_PENDING  = 2'd0,
    REG_CMD_ID       = 2'd1,
    REG_RESPONSE_LEN = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  // Framer phases
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_AWAIT   = 2'd1,
    PH_COLLECT = 2'd2,
    PH_EMIT    = 2'd3
  } phase_t;

  // Fixed frame length for ids FIRST_ID..LAST_ID, by offset from FIRST_ID
  function automatic logic [CNT_W-1:0] id_len(input logic [3:0] ofs);
    logic [CNT_W-1:0] len;
    unique case (ofs)
      4'd0:    len = CNT_W'(11);
      4'd1:    len = CNT_W'(25);
      4'd2:    len = CNT_W'(4);
      4'd3:    len = CNT_W'(10);
      4'd4:    len = CNT_W'(3);
      4'd5:    len = CNT_W'(2);
      4'd6:    len = CNT_W'(7);
      4'd7:    len = CNT_W'(10);
      4'd8:    len = CNT_W'(3);
      default: len = CNT_W'(2);
    endcase
    return len;
  endfunction

endpackage

[rtl/mrf_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrf_cell: one byte cell of the frame row
// Loads a received byte at its own slot, or takes its upper neighbor's
// byte when the row shifts toward the output during read-out.
// ---------------------------------------------------------------------------
module mrf_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] neighbor_byte,
  output logic [7:0] cell_byte
);

  // Hold, load or advance the stored byte
  always_ff @(posedge clk) begin
    if (load) begin
      cell_byte <= load_byte;
    end else if (shift) begin
      cell_byte <= neighbor_byte;
    end
  end

endmodule

[rtl/modem_reply_framer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modem_reply_framer: frames the reply byte stream of a power-line modem
// Hunts for a start byte, sizes the frame from its id, collects it in a row
// of byte cells and reads the finished frame out word by word.
// ---------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  s_*      | s_tvalid/tready  | tdata: rx_byte; tuser: cmd
//  m_*      | m_tvalid/tready  | tdata: out_byte, byte_index; tlast; tuser
//  cfg_*    | cfg_we           | cfg_index selects register, cfg_data value
//
// When a frame of L bytes completes, the row shifts toward cell 0 into the
// output register one byte per cycle while that register is empty or taken,
// and input is held off (s_tready low) until the last byte has entered the
// output register. rst is synchronous; it clears phase, counters and
// m_tvalid and sets the configuration registers to their reset values.
// ---------------------------------------------------------------------------
module modem_reply_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [12:8] byte_index, rest 0
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [0] kind, [1] acked
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import mrf_pkg::*;

  // Configuration registers
  logic             cmd_pending;
  logic [7:0]       cmd_id;
  logic [4:0]       response_len;

  // Framer state
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] expected_len, expected_len_next;
  logic             frame_kind, frame_kind_next;
  logic [CNT_W-1:0] emit_idx, emit_idx_next;

  // Cell row control
  logic             wr_en;
  logic [IDX_W-1:0] wr_ptr;
  logic [7:0]       wr_byte;
  logic             emit_go;
  logic             emit_last;
  logic [7:0]       row [MAX_FRAME];

  // Input decode
  logic             in_fire;
  logic [7:0]       b;
  logic             is_table_id;
  logic             is_resp_id;
  logic [CNT_W-1:0] table_len;
  logic [CNT_W-1:0] resp_len;
  logic [CNT_W-1:0] resp_clamped;
  logic [CNT_W-1:0] count_inc;

  assign s_tready = (phase != PH_EMIT);
  assign in_fire  = s_tvalid && s_tready;
  assign b        = s_tdata;

  assign is_table_id  = (b >= FIRST_ID) && (b <= LAST_ID);
  assign table_len    = id_len(4'(b - FIRST_ID));
  assign is_resp_id   = cmd_pending && (b == cmd_id);
  assign resp_len     = CNT_W'(response_len);
  assign resp_clamped = (resp_len < CNT_W'(2))         ? CNT_W'(2) :
                        (resp_len > CNT_W'(MAX_FRAME)) ? CNT_W'(MAX_FRAME) : resp_len;
  assign count_inc    = byte_count + CNT_W'(1);

  assign emit_go   = (phase == PH_EMIT) && (!m_tvalid || m_tready);
  assign emit_last = ((emit_idx + CNT_W'(1)) == expected_len);

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_pending  <= 1'b0;
      cmd_id       <= 8'h00;
      response_len <= 5'd3;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CMD_PENDING:  cmd_pending  <= cfg_data[0];
        REG_CMD_ID:       cmd_id       <= cfg_data;
        REG_RESPONSE_LEN: response_len <= cfg_data[4:0];
        REG_UNUSED:       ;
        default:          ;
      endcase
    end
  end

  // Phase and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_count   <= '0;
      expected_len <= '0;
      frame_kind   <= 1'b0;
      emit_idx     <= '0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      expected_len <= expected_len_next;
      frame_kind   <= frame_kind_next;
      emit_idx     <= emit_idx_next;
    end
  end

  // Next state, cell writes and read-out advance
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    expected_len_next = expected_len;
    frame_kind_next   = frame_kind;
    emit_idx_next     = emit_idx;
    wr_en             = 1'b0;
    wr_ptr            = '0;
    wr_byte           = b;

    if (phase == PH_EMIT) begin
      if (emit_go) begin
        if (emit_last) begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
          emit_idx_next   = '0;
        end else begin
          emit_idx_next = emit_idx + CNT_W'(1);
        end
      end
    end else if (in_fire) begin
      if (cmd_t'(s_tuser) == CMD_TIMEOUT) begin
        phase_next      = PH_HUNT;
        byte_count_next = '0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (b == START_BYTE) begin
              wr_en           = 1'b1;
              wr_ptr          = '0;
              byte_count_next = CNT_W'(1);
              phase_next      = PH_AWAIT;
            end
          end
          PH_AWAIT: begin
            if (is_table_id || is_resp_id) begin
              expected_len_next = is_table_id ? table_len : resp_clamped;
              frame_kind_next   = !is_table_id;
              wr_en             = 1'b1;
              wr_ptr            = IDX_W'(1);
              byte_count_next   = CNT_W'(2);
              emit_idx_next     = '0;
              phase_next        = ((is_table_id ? table_len : resp_clamped) <= CNT_W'(2))
                                  ? PH_EMIT : PH_COLLECT;
            end else if (b == START_BYTE) begin
              // Restart on a fresh start byte
              wr_en           = 1'b1;
              wr_ptr          = '0;
              byte_count_next = CNT_W'(1);
            end else begin
              phase_next      = PH_HUNT;
              byte_count_next = '0;
            end
          end
          PH_COLLECT: begin
            wr_en           = (byte_count < CNT_W'(MAX_FRAME));
            wr_ptr          = byte_count[IDX_W-1:0];
            byte_count_next = count_inc;
            emit_idx_next   = '0;
            if (count_inc >= expected_len) begin
              phase_next = PH_EMIT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Row of byte cells; read-out shifts toward cell 0
  for (genvar i = 0; i < MAX_FRAME; i++) begin : g_cell
    logic [7:0] upper;
    if (i == MAX_FRAME - 1) begin : g_top
      assign upper = 8'h00;
    end else begin : g_mid
      assign upper = row[i+1];
    end
    mrf_cell u_cell (
      .clk           (clk),
      .load          (wr_en && (wr_ptr == IDX_W'(i))),
      .shift         (emit_go),
      .load_byte     (wr_byte),
      .neighbor_byte (upper),
      .cell_byte     (row[i])
    );
  end

  // Output register: load from cell 0, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata    <= {3'b000, emit_idx[4:0], row[0]};
      m_tlast    <= emit_last;
      m_tuser[0] <= frame_kind;
      m_tuser[1] <= emit_last && frame_kind && (row[0] == ACK_BYTE);
    end
  end

endmodule
